// File: rtl/dap_pkg.sv
`default_nettype none

package dap_pkg;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Largest values that can still be scaled by ten or a hundred in 64 bits
    localparam logic [63:0] TENTH_OF_MAX     = 64'd1844674407370955161;
    localparam logic [63:0] HUNDREDTH_OF_MAX = 64'd184467440737095516;
    localparam logic [63:0] AMOUNT_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

    // Beyond nineteen padding zeros any nonzero amount overflows
    localparam logic [4:0] MAX_PAD = 5'd19;

    // Padding pipe: two decimal places per stage, plus one stage at entry
    localparam int PAD_STEPS = 10;
    localparam int NUM_STAGES = PAD_STEPS + 1;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;
    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    localparam t_cfg_index REG_FRACTION_PLACES = t_cfg_index'(0);
    localparam t_cfg_index REG_STRICT_MODE     = t_cfg_index'(1);

    // Terminated amount on its way through the padding pipe
    typedef struct packed {
        logic [63:0] acc;
        logic [4:0]  pad;
        logic        fail;
        logic        drop;
    } t_stage;

    // Append up to two zero digits, flagging a carry out of 64 bits
    function automatic t_stage pad_step(input t_stage s);
        t_stage r;
        r = s;
        if (s.pad >= 5'd2) begin
            if (s.acc > HUNDREDTH_OF_MAX) begin
                r.fail = 1'b1;
            end
            r.acc = (s.acc << 6) + (s.acc << 5) + (s.acc << 2);
            r.pad = s.pad - 5'd2;
        end else if (s.pad == 5'd1) begin
            if (s.acc > TENTH_OF_MAX) begin
                r.fail = 1'b1;
            end
            r.acc = (s.acc << 3) + (s.acc << 1);
            r.pad = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/decimal_amount_parser_top.sv
// Decimal amount parser: takes an ASCII amount one character per item and, on a
// terminator item, returns the amount scaled by 10^fraction_places as a 64-bit
// integer plus an ok flag. Every input item, character or terminator, can be taken
// in consecutive cycles as long as the result side does not stall. Characters
// update the running parse state in the cycle they are accepted and give no
// result. A terminator's result passes through the entry stage, then the
// zero-padding pipe, which appends up to nineteen trailing zeros at two decimal
// places per stage over ten stages, then the final rounding stage into the output
// register. Results of back-to-back terminators stream out one per cycle and in
// order while the receiver does not stall. Configuration writes are always ready
// and take effect at the next character or terminator.
`default_nettype none

module decimal_amount_parser_top
    import dap_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // input item channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_char_byte,
    input  wire logic                   i_end_mark,

    // result item channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [63:0]                 o_amount_value,
    output logic                        o_parse_ok,

    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // configuration registers
    logic [4:0]  r_places;
    logic        r_strict;

    // running parse state
    logic [63:0] r_acc,      n_acc;
    logic        r_ovf,      n_ovf;
    logic        r_point,    n_point;
    logic [4:0]  r_kept,     n_kept;
    logic        r_drop,     n_drop;
    logic        r_bad,      n_bad;
    logic        r_int_seen, n_int_seen;

    // padding pipe and output register
    t_stage                r_stage [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES:0]   w_ready;
    t_stage                w_entry;
    logic [4:0]            w_pad_raw;
    logic                  w_in_accept;
    logic                  w_term;
    logic [3:0]            w_digit;
    logic                  w_is_digit;
    logic                  w_push;
    logic [63:0]           w_pushed;
    logic                  w_push_ovf;
    logic                  n_ok;
    logic [63:0]           n_value;
    logic                  r_out_valid;
    logic [63:0]           r_out_value;
    logic                  r_out_ok;

    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_places <= 5'd8;
            r_strict <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FRACTION_PLACES: r_places <= i_cfg_data[4:0];
                REG_STRICT_MODE:     r_strict <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake: a stage takes new data when empty or when it drains onward
    assign w_ready[NUM_STAGES] = !r_out_valid || !i_out_stall;
    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_ready
        assign w_ready[k] = !r_vld[k] || w_ready[k+1];
    end

    assign o_in_stall  = !w_ready[0];
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_term      = w_in_accept && i_end_mark;

    // digit decode and accumulator times ten plus digit
    assign w_is_digit = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_NINE);
    assign w_digit    = 4'(i_char_byte - CH_ZERO);
    assign w_pushed   = (r_acc << 3) + (r_acc << 1) + 64'(w_digit);
    assign w_push_ovf = (r_acc > TENTH_OF_MAX) ||
                        ((r_acc == TENTH_OF_MAX) && (w_digit > 4'd5));

    // character step; a terminator clears the parse
    always_comb begin
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_point    = r_point;
        n_kept     = r_kept;
        n_drop     = r_drop;
        n_bad      = r_bad;
        n_int_seen = r_int_seen;
        w_push     = 1'b0;
        if (w_in_accept) begin
            if (i_end_mark) begin
                n_acc      = '0;
                n_ovf      = 1'b0;
                n_point    = 1'b0;
                n_kept     = '0;
                n_drop     = 1'b0;
                n_bad      = 1'b0;
                n_int_seen = 1'b0;
            end else if (i_char_byte == CH_POINT) begin
                if (r_point) begin
                    n_bad = 1'b1;
                end
                n_point = 1'b1;
            end else if (w_is_digit) begin
                if (!r_point) begin
                    n_int_seen = 1'b1;
                    w_push     = 1'b1;
                end else if (r_kept < r_places) begin
                    w_push = 1'b1;
                    n_kept = r_kept + 5'd1;
                end else if (w_digit != 4'd0) begin
                    n_drop = 1'b1;
                end
            end else begin
                n_bad = 1'b1;
            end
            if (w_push) begin
                n_acc = w_pushed;
                if (w_push_ovf) begin
                    n_ovf = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_ovf      <= 1'b0;
            r_point    <= 1'b0;
            r_kept     <= '0;
            r_drop     <= 1'b0;
            r_bad      <= 1'b0;
            r_int_seen <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_ovf      <= n_ovf;
            r_point    <= n_point;
            r_kept     <= n_kept;
            r_drop     <= n_drop;
            r_bad      <= n_bad;
            r_int_seen <= n_int_seen;
        end
    end

    // terminator entry: zeros still to pad and the failures known so far
    assign w_pad_raw = (r_kept < r_places) ? (r_places - r_kept) : 5'd0;

    always_comb begin
        w_entry.acc  = r_acc;
        w_entry.drop = r_drop;
        w_entry.pad  = w_pad_raw;
        w_entry.fail = r_bad || r_ovf ||
                       ((r_places == 5'd0) && !r_int_seen) ||
                       (r_drop && r_strict);
        if (w_pad_raw > MAX_PAD) begin
            // too many zeros: only a zero amount survives
            w_entry.pad = 5'd0;
            if (r_acc != 64'd0) begin
                w_entry.fail = 1'b1;
            end
        end
    end

    // padding pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ready[0]) begin
                r_vld[0] <= w_term;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // padding pipe payload
    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_stage[0] <= w_entry;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_ready[k]) begin
                r_stage[k] <= pad_step(r_stage[k-1]);
            end
        end
    end

    // rounding and final check
    always_comb begin
        n_ok = !r_stage[NUM_STAGES-1].fail &&
               !(r_stage[NUM_STAGES-1].drop && (r_stage[NUM_STAGES-1].acc == AMOUNT_MAX));
        n_value = n_ok ? (r_stage[NUM_STAGES-1].acc + 64'(r_stage[NUM_STAGES-1].drop))
                       : 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ready[NUM_STAGES]) begin
            r_out_valid <= r_vld[NUM_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[NUM_STAGES]) begin
            r_out_value <= n_value;
            r_out_ok    <= n_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_amount_value = r_out_value;
    assign o_parse_ok     = r_out_ok;

`ifndef SYNTHESIS
    // all padding is done by the last pipe stage
    a_pad_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STAGES-1] |-> (r_stage[NUM_STAGES-1].pad == 5'd0))
        else $error("padding not finished at end of pipe");

    // entry never asks for more zeros than the pipe can append
    a_pad_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_stage[0].pad <= MAX_PAD))
        else $error("padding count out of range");

    // a failed parse reports a zero amount
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_parse_ok) |-> (o_amount_value == 64'd0))
        else $error("failed parse with nonzero amount");

    // a terminator leaves a clean parse state behind
    a_term_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_term |=> ((r_acc == 64'd0) && !r_point && !r_bad && !r_ovf && (r_kept == 5'd0)))
        else $error("parse state not cleared after terminator");

    // the last pipe stage holding an item with a stalled output keeps it
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-1] && !w_ready[NUM_STAGES]) |=> r_vld[NUM_STAGES-1])
        else $error("item lost in padding pipe");
`endif

endmodule

`default_nettype wire

// File: test/tb_decimal_amount_parser_top.sv
`timescale 1ns / 1ps

module tb_decimal_amount_parser_top;
    import dap_pkg::*;

    // ASCII codes the parser reacts to
    localparam logic [7:0]  ASCII_POINT = 8'h2E;
    localparam logic [7:0]  ASCII_ZERO  = 8'h30;
    localparam logic [7:0]  ASCII_NINE  = 8'h39;
    localparam logic [63:0] TENTH_LIMIT = 64'd1844674407370955161;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    // Index with no register behind it
    localparam t_cfg_index  REG_UNUSED  = t_cfg_index'(15);

    typedef struct {
        logic [63:0] value;
        logic        ok;
    } t_amount;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [7:0]             i_char_byte;
    logic                   i_end_mark;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [63:0]            o_amount_value;
    logic                   o_parse_ok;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    decimal_amount_parser_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_end_mark     (i_end_mark),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_amount_value (o_amount_value),
        .o_parse_ok     (o_parse_ok),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Parser state as the block should hold it
    logic [4:0]  places_m;
    logic        strict_m;
    logic [63:0] acc_m;
    logic        ovf_m;
    logic        point_m;
    logic [4:0]  kept_m;
    logic        drop_m;
    logic        bad_m;
    logic        intdig_m;

    t_amount     expected_amounts[$];
    logic [7:0]  amt_q[$];
    int          err_count = 0;
    int          items_sent = 0;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Amount prediction
    // ---------------------------------------------------------------
    function automatic void clear_amount();
        acc_m    = '0;
        ovf_m    = 1'b0;
        point_m  = 1'b0;
        kept_m   = '0;
        drop_m   = 1'b0;
        bad_m    = 1'b0;
        intdig_m = 1'b0;
    endfunction

    // acc = acc * 10 + digit, noting a carry out of 64 bits
    function automatic void shift_in_digit(input logic [3:0] digit);
        if (acc_m > TENTH_LIMIT || (acc_m == TENTH_LIMIT && digit > 4'd5)) begin
            ovf_m = 1'b1;
        end
        acc_m = acc_m * 64'd10 + 64'(digit);
    endfunction

    // Returns 1 when the item yields an amount
    function automatic bit parse_item(input logic [7:0] ch, input logic eom,
                                      output t_amount res);
        logic [4:0] k;
        logic       ok;
        res.value = '0;
        res.ok    = 1'b0;
        if (!eom) begin
            if (ch == ASCII_POINT) begin
                if (point_m) begin
                    bad_m = 1'b1;
                end
                point_m = 1'b1;
            end else if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
                if (!point_m) begin
                    intdig_m = 1'b1;
                    shift_in_digit(4'(ch - ASCII_ZERO));
                end else if (kept_m < places_m) begin
                    shift_in_digit(4'(ch - ASCII_ZERO));
                    kept_m = kept_m + 5'd1;
                end else if (ch != ASCII_ZERO) begin
                    drop_m = 1'b1;
                end
            end else begin
                bad_m = 1'b1;
            end
            return 1'b0;
        end
        // terminator: pad missing fraction digits, then round
        k = kept_m;
        while (k < places_m) begin
            shift_in_digit(4'd0);
            k = k + 5'd1;
        end
        ok = !(bad_m || ovf_m);
        if (places_m == 5'd0 && !intdig_m) ok = 1'b0;
        if (drop_m && strict_m) ok = 1'b0;
        if (drop_m && acc_m == ALL_ONES) ok = 1'b0;
        if (ok) begin
            res.value = acc_m + 64'(drop_m);
            res.ok    = 1'b1;
        end
        clear_amount();
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_amount want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_amounts.size() == 0) begin
                report_mismatch("unexpected result", o_amount_value, 64'd0);
            end else begin
                want = expected_amounts.pop_front();
                if (o_amount_value !== want.value) begin
                    report_mismatch("amount_value", o_amount_value, want.value);
                end
                if (o_parse_ok !== want.ok) begin
                    report_mismatch("parse_ok", 64'(o_parse_ok), 64'(want.ok));
                end
            end
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Leaves valid high after acceptance; the next call replaces or drops it, wait_idle drops it
    task automatic send_item(input logic [7:0] ch, input logic eom);
        t_amount res;
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= ch;
        i_end_mark  <= eom;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (parse_item(ch, eom, res)) begin
            expected_amounts.push_back(res);
        end
    endtask

    task automatic send_amount(input bit terminate);
        foreach (amt_q[i]) send_item(amt_q[i], 1'b0);
        if (terminate) send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic void load_text(input string s);
        amt_q.delete();
        for (int i = 0; i < s.len(); i++) amt_q.push_back(s[i]);
    endfunction

    task automatic send_text(input string s);
        load_text(s);
        send_amount(1'b1);
    endtask

    // Drop valid, drain all pending amounts and let the pad pipe empty
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_amounts.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_FRACTION_PLACES) begin
            places_m = data[4:0];
        end else if (idx == REG_STRICT_MODE) begin
            strict_m = data[0];
        end
    endtask

    task automatic set_config(input logic [4:0] places, input logic strict);
        write_reg(REG_FRACTION_PLACES, {3'($urandom_range(0, 7)), places});
        write_reg(REG_STRICT_MODE, {7'($urandom_range(0, 127)), strict});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_digit();
        if ($urandom_range(0, 3) == 0) return ASCII_ZERO;
        return ASCII_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Mostly well-formed amounts sized to the current places, some noise
    task automatic build_random_amount();
        int kind;
        int int_len;
        int frac_len;
        int room;
        int pos;
        logic [7:0] junk;
        amt_q.delete();
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            repeat ($urandom_range(1, 4)) amt_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind == 1) begin
            // close to the 64-bit limit
            load_text("1844674407370955161");
            amt_q.push_back(ASCII_ZERO + 8'($urandom_range(4, 7)));
            if ($urandom_range(0, 1) == 1) begin
                amt_q.push_back(ASCII_POINT);
                amt_q.push_back(ASCII_ZERO + 8'($urandom_range(0, 1)));
            end
        end else begin
            room = (places_m < 19) ? 19 - int'(places_m) : 1;
            int_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 21)
                                                  : $urandom_range(0, room);
            repeat (int_len) amt_q.push_back(random_digit());
            if ($urandom_range(0, 3) != 0) begin
                amt_q.push_back(ASCII_POINT);
                frac_len = $urandom_range(0, int'(places_m) + 3);
                if (frac_len > 24) frac_len = 24;
                repeat (frac_len) amt_q.push_back(random_digit());
            end
            // broken amount: stray byte or second point
            if (kind == 2) begin
                pos  = $urandom_range(0, amt_q.size());
                junk = ($urandom_range(0, 1) == 1) ? ASCII_POINT : 8'($urandom_range(0, 255));
                amt_q.insert(pos, junk);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset values: eight places, rounding allowed
    task automatic test_reset_defaults();
        send_text("0");
        send_text("123.45");
        send_text("");
        send_text(".");
        send_text("1.234567891");
    endtask

    // Zero places: full 64-bit range, empty digit strings, rounding edges
    task automatic test_whole_units();
        wait_idle();
        set_config(5'd0, 1'b0);
        send_text("18446744073709551615");
        send_text("18446744073709551616");
        send_text("");
        send_text(".");
        send_text(".5");
        send_text("7.5");
        send_text("18446744073709551615.9");
    endtask

    task automatic test_bad_characters();
        wait_idle();
        set_config(5'd2, 1'b0);
        send_text("1a");
        send_text("1..2");
        send_text("/");
        send_text(":");
        amt_q = '{8'hFF};
        send_amount(1'b1);
        amt_q = '{8'h00, ASCII_ZERO};
        send_amount(1'b1);
    endtask

    // Padding overflow at nineteen places and beyond
    task automatic test_places_limits();
        wait_idle();
        set_config(5'd19, 1'b0);
        send_text("1");
        send_text("2");
        send_text(".1234567890123456789");
        wait_idle();
        write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        set_config(5'd31, 1'b0);
        send_text("0");
        send_text("1");
        send_text("");
    endtask

    task automatic test_strict_mode();
        wait_idle();
        set_config(5'd8, 1'b1);
        send_text("1.123456789");
        send_text("1.1234567800");
        wait_idle();
        set_config(5'd0, 1'b1);
        send_text("5.0");
        send_text("5.1");
    endtask

    // Places changed while an amount is half entered
    task automatic test_places_change();
        wait_idle();
        set_config(5'd2, 1'b0);
        load_text("1.2345");
        send_amount(1'b0);
        wait_idle();
        set_config(5'd6, 1'b0);
        send_text("67");
        wait_idle();
        set_config(5'd8, 1'b0);
        load_text("1.2345");
        send_amount(1'b0);
        wait_idle();
        set_config(5'd2, 1'b0);
        send_text("");
    endtask

    task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_items);
        int target;
        int burst_end;
        int phase;
        logic [4:0] places;
        target = items_sent + n_items;
        phase  = 0;
        while (items_sent < target) begin
            wait_idle();
            in_idle_pct   = in_pct;
            out_stall_pct = out_pct;
            case (phase % 5)
                0:       places = 5'd0;
                1:       places = 5'd19;
                2:       places = 5'($urandom_range(20, 31));
                default: places = 5'($urandom_range(0, 19));
            endcase
            set_config(places, 1'($urandom_range(0, 1)));
            burst_end = items_sent + 60;
            while (items_sent < burst_end && items_sent < target) begin
                build_random_amount();
                send_amount(1'b1);
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_char_byte = '0;
        i_end_mark  = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        places_m    = 5'd8;
        strict_m    = 1'b0;
        clear_amount();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct   = 29;
        out_stall_pct = 60;
        test_reset_defaults();
        test_whole_units();
        test_bad_characters();
        test_places_limits();
        test_strict_mode();
        test_places_change();

        test_random_traffic(29, 60, 220);
        test_random_traffic(60, 29, 220);
        test_random_traffic(0, 0, 220);
        wait_idle();

        if (err_count == 0 && expected_amounts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
